@@ src/modular_square_root_assert.svh @@
// ----------------------------------------------------------------------------
// modular square root assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef MODULAR_SQUARE_ROOT_ASSERT_SVH
`define MODULAR_SQUARE_ROOT_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define MSQRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("msqrt assertion failed");
// expression must never be true outside reset
`define MSQRT_NEVER(lbl, clk, rstn, expr) \
  `MSQRT_ASSERT(lbl, clk, rstn, !(expr))
`else
`define MSQRT_ASSERT(lbl, clk, rstn, prop)
`define MSQRT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ src/msqrt_pkg.sv @@
// ----------------------------------------------------------------------------
// msqrt_pkg
// command and status types shared by the controller and the datapath
// ----------------------------------------------------------------------------
package msqrt_pkg;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_MUL,
    DP_POW_INIT,
    DP_EXP_SHIFT,
    DP_FACT_INIT,
    DP_FACT_SHIFT,
    DP_Z_INIT,
    DP_Z_NEXT,
    DP_COPY_ACC,
    DP_LOOP_INIT,
    DP_T2_INIT,
    DP_I_INC,
    DP_B_INIT,
    DP_J_INC,
    DP_ROUND_END
  } dp_op_e;

  // result writes, kept apart from the working ops
  typedef enum logic [1:0] {
    RES_NONE,
    RES_FAIL,
    RES_ACC,
    RES_R
  } res_op_e;

  // multiplier operand and pow base sources
  typedef enum logic [3:0] {
    OPD_ONE,
    OPD_A,
    OPD_Z,
    OPD_ACC,
    OPD_BASE,
    OPD_T2,
    OPD_B,
    OPD_C,
    OPD_T,
    OPD_R
  } opd_e;

  // destinations of a product or of a pow result copy
  typedef enum logic [2:0] {
    DST_A,
    DST_ACC,
    DST_BASE,
    DST_T2,
    DST_B,
    DST_C,
    DST_T,
    DST_R
  } dst_e;

  // pow exponent sources
  typedef enum logic [1:0] {
    EXP_K,
    EXP_P4,
    EXP_Q,
    EXP_QH
  } exp_e;

  typedef struct packed {
    dp_op_e  op;
    res_op_e res;
    opd_e    x_sel;
    opd_e    y_sel;
    dst_e    dst;
    exp_e    exp_sel;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic p_bad;
    logic p_mod4_3;
    logic q_even;
    logic z_stop;
    logic exp_zero;
    logic exp_lsb;
    logic acc_one;
    logic t_one;
    logic t2_one;
    logic rounds_max;
    logic i_stop;
    logic j_more;
  } status_t;

endpackage

@@ src/msqrt_mulmod.sv @@
// ----------------------------------------------------------------------------
// msqrt_mulmod
// bit-serial modular multiplier, one bit of y per cycle, msb first
// ----------------------------------------------------------------------------
`include "modular_square_root_assert.svh"

module msqrt_mulmod #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] p_i,
  output logic             done_o,
  output logic [WIDTH-1:0] result_o
);

  localparam int CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q;
  logic [WIDTH-1:0] y_q;
  logic [CntW-1:0]  cnt_q;
  logic             busy_q;
  logic             done_q;
  logic [WIDTH-1:0] dbl;

  // (u + v) mod p for u, v < p
  function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] u,
                                               input logic [WIDTH-1:0] v,
                                               input logic [WIDTH-1:0] p);
    logic [WIDTH:0] sum;
    sum = {1'b0, u} + {1'b0, v};
    if (sum >= {1'b0, p}) begin
      sum = sum - {1'b0, p};
    end
    return sum[WIDTH-1:0];
  endfunction

  always_comb begin
    dbl   = add_mod(acc_q, acc_q, p_i);
    acc_d = y_q[WIDTH-1] ? add_mod(dbl, x_q, p_i) : dbl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CntW'(1);
        if (cnt_q == CntW'(WIDTH - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      x_q   <= x_i;
      y_q   <= y_i;
    end else if (busy_q) begin
      acc_q <= acc_d;
      y_q   <= {y_q[WIDTH-2:0], 1'b0};
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

  `MSQRT_NEVER(a_start_while_busy, clk_i, rst_ni, start_i && busy_q)
  `MSQRT_ASSERT(a_result_reduced, clk_i, rst_ni, done_q |-> (acc_q < p_i))

endmodule

@@ src/msqrt_dp.sv @@
// ----------------------------------------------------------------------------
// msqrt_dp
// working registers, loop counters and the shared modular multiplier
// ----------------------------------------------------------------------------
module msqrt_dp #(
  parameter int WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  msqrt_pkg::cmd_t   cmd_i,
  input  logic [WIDTH-1:0]  value_i,
  input  logic [WIDTH-1:0]  prime_i,
  output msqrt_pkg::status_t status_o,
  output logic [WIDTH-1:0]  root_o,
  output logic              has_root_o
);

  localparam int CW = $clog2(WIDTH + 1);
  localparam int TW = $clog2(16 * WIDTH + 1);

  logic [WIDTH-1:0] p_q, a_q, q_q, z_q, c_q, t_q, r_q, b_q;
  logic [WIDTH-1:0] acc_q, base_q, exp_q, t2_q;
  logic [CW-1:0]    s_q, m_q, i_q, j_q, rounds_q;
  logic [TW-1:0]    tries_q;
  msqrt_pkg::dst_e  dst_q;
  logic [WIDTH-1:0] root_q;
  logic             ok_q;

  logic             mul_start;
  logic             mul_done;
  logic [WIDTH-1:0] mul_res;
  logic [WIDTH-1:0] opd_x, opd_y, pow_base, exp_src;

  function automatic logic [WIDTH-1:0] pick(input msqrt_pkg::opd_e sel,
                                            input logic [WIDTH-1:0] a,
                                            input logic [WIDTH-1:0] z,
                                            input logic [WIDTH-1:0] acc,
                                            input logic [WIDTH-1:0] base,
                                            input logic [WIDTH-1:0] t2,
                                            input logic [WIDTH-1:0] b,
                                            input logic [WIDTH-1:0] c,
                                            input logic [WIDTH-1:0] t,
                                            input logic [WIDTH-1:0] r);
    logic [WIDTH-1:0] v;
    unique case (sel)
      msqrt_pkg::OPD_ONE:  v = WIDTH'(1);
      msqrt_pkg::OPD_A:    v = a;
      msqrt_pkg::OPD_Z:    v = z;
      msqrt_pkg::OPD_ACC:  v = acc;
      msqrt_pkg::OPD_BASE: v = base;
      msqrt_pkg::OPD_T2:   v = t2;
      msqrt_pkg::OPD_B:    v = b;
      msqrt_pkg::OPD_C:    v = c;
      msqrt_pkg::OPD_T:    v = t;
      msqrt_pkg::OPD_R:    v = r;
      default:             v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    opd_x    = pick(cmd_i.x_sel, a_q, z_q, acc_q, base_q, t2_q, b_q, c_q, t_q, r_q);
    opd_y    = pick(cmd_i.y_sel, a_q, z_q, acc_q, base_q, t2_q, b_q, c_q, t_q, r_q);
    pow_base = opd_x;
    unique case (cmd_i.exp_sel)
      msqrt_pkg::EXP_K:  exp_src = p_q >> 1;
      msqrt_pkg::EXP_P4: exp_src = (p_q >> 2) + WIDTH'(1);
      msqrt_pkg::EXP_Q:  exp_src = q_q;
      msqrt_pkg::EXP_QH: exp_src = (q_q >> 1) + WIDTH'(1);
      default:           exp_src = q_q;
    endcase
  end

  assign mul_start = (cmd_i.op == msqrt_pkg::DP_MUL);

  msqrt_mulmod #(
    .WIDTH(WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (opd_x),
    .y_i     (opd_y),
    .p_i     (p_q),
    .done_o  (mul_done),
    .result_o(mul_res)
  );

  always_ff @(posedge clk_i) begin
    // product write-back
    if (mul_done) begin
      unique case (dst_q)
        msqrt_pkg::DST_A:    a_q    <= mul_res;
        msqrt_pkg::DST_ACC:  acc_q  <= mul_res;
        msqrt_pkg::DST_BASE: base_q <= mul_res;
        msqrt_pkg::DST_T2:   t2_q   <= mul_res;
        msqrt_pkg::DST_B:    b_q    <= mul_res;
        msqrt_pkg::DST_C:    c_q    <= mul_res;
        msqrt_pkg::DST_T:    t_q    <= mul_res;
        msqrt_pkg::DST_R:    r_q    <= mul_res;
        default:             a_q    <= mul_res;
      endcase
    end
    unique case (cmd_i.op)
      msqrt_pkg::DP_NOP: begin
      end
      msqrt_pkg::DP_LOAD: begin
        a_q <= value_i;
        p_q <= prime_i;
      end
      msqrt_pkg::DP_MUL: begin
        dst_q <= cmd_i.dst;
      end
      msqrt_pkg::DP_POW_INIT: begin
        acc_q  <= WIDTH'(1);
        base_q <= pow_base;
        exp_q  <= exp_src;
      end
      msqrt_pkg::DP_EXP_SHIFT: begin
        exp_q <= exp_q >> 1;
      end
      msqrt_pkg::DP_FACT_INIT: begin
        q_q <= p_q - WIDTH'(1);
        s_q <= '0;
      end
      msqrt_pkg::DP_FACT_SHIFT: begin
        q_q <= q_q >> 1;
        s_q <= s_q + CW'(1);
      end
      msqrt_pkg::DP_Z_INIT: begin
        z_q     <= WIDTH'(2);
        tries_q <= '0;
      end
      msqrt_pkg::DP_Z_NEXT: begin
        z_q     <= z_q + WIDTH'(1);
        tries_q <= tries_q + TW'(1);
      end
      msqrt_pkg::DP_COPY_ACC: begin
        unique case (cmd_i.dst)
          msqrt_pkg::DST_C: c_q <= acc_q;
          msqrt_pkg::DST_T: t_q <= acc_q;
          default:          r_q <= acc_q;
        endcase
      end
      msqrt_pkg::DP_LOOP_INIT: begin
        m_q      <= s_q;
        rounds_q <= '0;
      end
      msqrt_pkg::DP_T2_INIT: begin
        t2_q <= t_q;
        i_q  <= '0;
      end
      msqrt_pkg::DP_I_INC: begin
        i_q <= i_q + CW'(1);
      end
      msqrt_pkg::DP_B_INIT: begin
        b_q <= c_q;
        j_q <= '0;
      end
      msqrt_pkg::DP_J_INC: begin
        j_q <= j_q + CW'(1);
      end
      msqrt_pkg::DP_ROUND_END: begin
        m_q      <= i_q;
        rounds_q <= rounds_q + CW'(1);
      end
      default: begin
      end
    endcase
    unique case (cmd_i.res)
      msqrt_pkg::RES_NONE: begin
      end
      msqrt_pkg::RES_FAIL: begin
        root_q <= '0;
        ok_q   <= 1'b0;
      end
      msqrt_pkg::RES_ACC: begin
        root_q <= acc_q;
        ok_q   <= 1'b1;
      end
      msqrt_pkg::RES_R: begin
        root_q <= r_q;
        ok_q   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    status_o.mul_done   = mul_done;
    status_o.p_bad      = (p_q < WIDTH'(3)) || !p_q[0];
    status_o.p_mod4_3   = (p_q[1:0] == 2'b11);
    status_o.q_even     = !q_q[0];
    status_o.z_stop     = (z_q >= p_q) || (tries_q >= TW'(16 * WIDTH));
    status_o.exp_zero   = (exp_q == '0);
    status_o.exp_lsb    = exp_q[0];
    status_o.acc_one    = (acc_q == WIDTH'(1));
    status_o.t_one      = (t_q == WIDTH'(1));
    status_o.t2_one     = (t2_q == WIDTH'(1));
    status_o.rounds_max = (rounds_q >= CW'(WIDTH));
    status_o.i_stop     = ({1'b0, i_q} + (CW + 1)'(1)) >= {1'b0, m_q};
    status_o.j_more     = ({1'b0, j_q} + {1'b0, i_q} + (CW + 1)'(1)) < {1'b0, m_q};
  end

  assign root_o     = root_q;
  assign has_root_o = ok_q;

endmodule

@@ src/msqrt_ctrl.sv @@
// ----------------------------------------------------------------------------
// msqrt_ctrl
// sequencer for euler test, factoring, non-residue search and main loop
// ----------------------------------------------------------------------------
module msqrt_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  msqrt_pkg::status_t status_i,
  output msqrt_pkg::cmd_t    cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_CHECK, S_REDUCE_W, S_EULER, S_EULER_CHK,
    S_POW, S_POW_MUL_W, S_POW_SQ, S_POW_SQ_W,
    S_FACT, S_Z_TEST, S_Z_CHK,
    S_C_SAVE, S_T_POW, S_T_SAVE, S_R_POW, S_R_SAVE,
    S_LOOP, S_SQ, S_SQ_W, S_BSQ, S_BSQ_W,
    S_UPD_C_W, S_UPD_T, S_UPD_T_W, S_UPD_R, S_UPD_R_W, S_ROUND_END,
    S_FAIL, S_PASS_ACC, S_PASS_R
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d       = state_q;
    ret_d         = ret_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.op      = msqrt_pkg::DP_NOP;
    cmd_o.res     = msqrt_pkg::RES_NONE;
    cmd_o.x_sel   = msqrt_pkg::OPD_ONE;
    cmd_o.y_sel   = msqrt_pkg::OPD_ONE;
    cmd_o.dst     = msqrt_pkg::DST_A;
    cmd_o.exp_sel = msqrt_pkg::EXP_K;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = msqrt_pkg::DP_LOAD;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.p_bad) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.op    = msqrt_pkg::DP_MUL;
          cmd_o.x_sel = msqrt_pkg::OPD_ONE;
          cmd_o.y_sel = msqrt_pkg::OPD_A;
          cmd_o.dst   = msqrt_pkg::DST_A;
          state_d     = S_REDUCE_W;
        end
      end
      S_REDUCE_W: if (status_i.mul_done) state_d = S_EULER;
      S_EULER: begin
        cmd_o.op      = msqrt_pkg::DP_POW_INIT;
        cmd_o.x_sel   = msqrt_pkg::OPD_A;
        cmd_o.exp_sel = msqrt_pkg::EXP_K;
        ret_d         = S_EULER_CHK;
        state_d       = S_POW;
      end
      S_POW: begin
        if (status_i.exp_zero) begin
          state_d = ret_q;
        end else if (status_i.exp_lsb) begin
          cmd_o.op    = msqrt_pkg::DP_MUL;
          cmd_o.x_sel = msqrt_pkg::OPD_ACC;
          cmd_o.y_sel = msqrt_pkg::OPD_BASE;
          cmd_o.dst   = msqrt_pkg::DST_ACC;
          state_d     = S_POW_MUL_W;
        end else begin
          state_d = S_POW_SQ;
        end
      end
      S_POW_MUL_W: if (status_i.mul_done) state_d = S_POW_SQ;
      S_POW_SQ: begin
        cmd_o.op    = msqrt_pkg::DP_MUL;
        cmd_o.x_sel = msqrt_pkg::OPD_BASE;
        cmd_o.y_sel = msqrt_pkg::OPD_BASE;
        cmd_o.dst   = msqrt_pkg::DST_BASE;
        state_d     = S_POW_SQ_W;
      end
      S_POW_SQ_W: begin
        if (status_i.mul_done) begin
          cmd_o.op = msqrt_pkg::DP_EXP_SHIFT;
          state_d  = S_POW;
        end
      end
      S_EULER_CHK: begin
        if (!status_i.acc_one) begin
          state_d = S_FAIL;
        end else if (status_i.p_mod4_3) begin
          cmd_o.op      = msqrt_pkg::DP_POW_INIT;
          cmd_o.x_sel   = msqrt_pkg::OPD_A;
          cmd_o.exp_sel = msqrt_pkg::EXP_P4;
          ret_d         = S_PASS_ACC;
          state_d       = S_POW;
        end else begin
          cmd_o.op = msqrt_pkg::DP_FACT_INIT;
          state_d  = S_FACT;
        end
      end
      S_FACT: begin
        if (status_i.q_even) begin
          cmd_o.op = msqrt_pkg::DP_FACT_SHIFT;
        end else begin
          cmd_o.op = msqrt_pkg::DP_Z_INIT;
          state_d  = S_Z_TEST;
        end
      end
      S_Z_TEST: begin
        if (status_i.z_stop) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.op      = msqrt_pkg::DP_POW_INIT;
          cmd_o.x_sel   = msqrt_pkg::OPD_Z;
          cmd_o.exp_sel = msqrt_pkg::EXP_K;
          ret_d         = S_Z_CHK;
          state_d       = S_POW;
        end
      end
      S_Z_CHK: begin
        if (status_i.acc_one) begin
          cmd_o.op = msqrt_pkg::DP_Z_NEXT;
          state_d  = S_Z_TEST;
        end else begin
          cmd_o.op      = msqrt_pkg::DP_POW_INIT;
          cmd_o.x_sel   = msqrt_pkg::OPD_Z;
          cmd_o.exp_sel = msqrt_pkg::EXP_Q;
          ret_d         = S_C_SAVE;
          state_d       = S_POW;
        end
      end
      S_C_SAVE: begin
        cmd_o.op  = msqrt_pkg::DP_COPY_ACC;
        cmd_o.dst = msqrt_pkg::DST_C;
        state_d   = S_T_POW;
      end
      S_T_POW: begin
        cmd_o.op      = msqrt_pkg::DP_POW_INIT;
        cmd_o.x_sel   = msqrt_pkg::OPD_A;
        cmd_o.exp_sel = msqrt_pkg::EXP_Q;
        ret_d         = S_T_SAVE;
        state_d       = S_POW;
      end
      S_T_SAVE: begin
        cmd_o.op  = msqrt_pkg::DP_COPY_ACC;
        cmd_o.dst = msqrt_pkg::DST_T;
        state_d   = S_R_POW;
      end
      S_R_POW: begin
        cmd_o.op      = msqrt_pkg::DP_POW_INIT;
        cmd_o.x_sel   = msqrt_pkg::OPD_A;
        cmd_o.exp_sel = msqrt_pkg::EXP_QH;
        ret_d         = S_R_SAVE;
        state_d       = S_POW;
      end
      S_R_SAVE: begin
        cmd_o.op  = msqrt_pkg::DP_COPY_ACC;
        cmd_o.dst = msqrt_pkg::DST_R;
        state_d   = S_ROUND_END;
        ret_d     = S_LOOP;
      end
      S_LOOP: begin
        if (status_i.t_one) begin
          state_d = S_PASS_R;
        end else if (status_i.rounds_max) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.op = msqrt_pkg::DP_T2_INIT;
          state_d  = S_SQ;
        end
      end
      S_SQ: begin
        if (status_i.t2_one) begin
          cmd_o.op = msqrt_pkg::DP_B_INIT;
          state_d  = S_BSQ;
        end else if (status_i.i_stop) begin
          state_d = S_FAIL;
        end else begin
          cmd_o.op    = msqrt_pkg::DP_MUL;
          cmd_o.x_sel = msqrt_pkg::OPD_T2;
          cmd_o.y_sel = msqrt_pkg::OPD_T2;
          cmd_o.dst   = msqrt_pkg::DST_T2;
          state_d     = S_SQ_W;
        end
      end
      S_SQ_W: begin
        if (status_i.mul_done) begin
          cmd_o.op = msqrt_pkg::DP_I_INC;
          state_d  = S_SQ;
        end
      end
      S_BSQ: begin
        cmd_o.op    = msqrt_pkg::DP_MUL;
        cmd_o.x_sel = msqrt_pkg::OPD_B;
        cmd_o.y_sel = msqrt_pkg::OPD_B;
        if (status_i.j_more) begin
          cmd_o.dst = msqrt_pkg::DST_B;
          state_d   = S_BSQ_W;
        end else begin
          cmd_o.dst = msqrt_pkg::DST_C;
          state_d   = S_UPD_C_W;
        end
      end
      S_BSQ_W: begin
        if (status_i.mul_done) begin
          cmd_o.op = msqrt_pkg::DP_J_INC;
          state_d  = S_BSQ;
        end
      end
      S_UPD_C_W: if (status_i.mul_done) state_d = S_UPD_T;
      S_UPD_T: begin
        cmd_o.op    = msqrt_pkg::DP_MUL;
        cmd_o.x_sel = msqrt_pkg::OPD_T;
        cmd_o.y_sel = msqrt_pkg::OPD_C;
        cmd_o.dst   = msqrt_pkg::DST_T;
        state_d     = S_UPD_T_W;
      end
      S_UPD_T_W: if (status_i.mul_done) state_d = S_UPD_R;
      S_UPD_R: begin
        cmd_o.op    = msqrt_pkg::DP_MUL;
        cmd_o.x_sel = msqrt_pkg::OPD_R;
        cmd_o.y_sel = msqrt_pkg::OPD_B;
        cmd_o.dst   = msqrt_pkg::DST_R;
        state_d     = S_UPD_R_W;
      end
      S_UPD_R_W: if (status_i.mul_done) state_d = S_ROUND_END;
      S_ROUND_END: begin
        // entered from setup with ret at loop start: set m and clear rounds
        if (ret_q == S_LOOP) begin
          cmd_o.op = msqrt_pkg::DP_LOOP_INIT;
          ret_d    = S_IDLE;
        end else begin
          cmd_o.op = msqrt_pkg::DP_ROUND_END;
        end
        state_d = S_LOOP;
      end
      S_FAIL, S_PASS_ACC, S_PASS_R: begin
        if (slot_free) begin
          priority if (state_q == S_FAIL) begin
            cmd_o.res = msqrt_pkg::RES_FAIL;
          end else if (state_q == S_PASS_ACC) begin
            cmd_o.res = msqrt_pkg::RES_ACC;
          end else begin
            cmd_o.res = msqrt_pkg::RES_R;
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ src/modular_square_root.sv @@
// ----------------------------------------------------------------------------
// modular_square_root
// tonelli-shanks square root modulo an odd prime, one shared multiplier
// ----------------------------------------------------------------------------
// Takes a value and an odd prime modulus and answers a root r with
// r*r == value mod p, or has_root 0 with root 0. Both inputs are cut to
// their low WIDTH bits. Euler's test runs first, so a value that is zero
// mod p reports no root; moduli below three or even report no root too.
// Primes that are 3 mod 4 take one exponentiation to (p+1)/4, all others
// run the full Tonelli-Shanks loop, capped at WIDTH rounds. Every product
// goes through one bit-serial modular multiplier, so that multiplier sets
// the latency: an exponentiation with an n-bit exponent costs up to 2n
// products. A 3 mod 4 prime takes Euler's exponentiation and one more;
// other primes add one exponentiation per tried non-residue candidate,
// three setup exponentiations and up to WIDTH rounds of at most about
// WIDTH+1 products each. One item is processed at a time; a finished
// result waits in an output register, and the next item is accepted
// while it waits.
// ----------------------------------------------------------------------------
`include "modular_square_root_assert.svh"

module modular_square_root #(
  parameter int WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_i,
  input  logic [31:0] prime_modulus_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] root_o,
  output logic        has_root_o
);

  msqrt_pkg::cmd_t    cmd;
  msqrt_pkg::status_t status;

  // operands cut or widened to the working width
  logic [WIDTH-1:0] value_w;
  logic [WIDTH-1:0] prime_w;
  logic [WIDTH-1:0] root_w;

  assign value_w = WIDTH'(value_i);
  assign prime_w = WIDTH'(prime_modulus_i);
  assign root_o  = 32'(root_w);

  // sequencer: decides every step from datapath status flags
  msqrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // working registers, counters and modular multiplier
  msqrt_dp #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .value_i   (value_w),
    .prime_i   (prime_w),
    .status_o  (status),
    .root_o    (root_w),
    .has_root_o(has_root_o)
  );

  // a missing root is always reported as zero
  `MSQRT_ASSERT(a_no_root_zero, clk_i, rst_ni, (out_valid_o && !has_root_o) |-> root_o == '0)
  // a request is never taken twice in a row
  `MSQRT_ASSERT(a_one_at_a_time, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o)

endmodule
